// ===== design/ipaf_pkg.sv =====
// Shared types and constants for the IPv4 endpoint allowlist filter.
// Used by ipaf_cell, ipaf_ctrl and the top level; depends on nothing.
package ipaf_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;
    // Entry index carried along the chain; covers tables of up to 256 entries.
    localparam int unsigned IDX_W = 8;

    localparam logic [15:0] ET_IPV4 = 16'h0008;
    localparam logic [15:0] ET_IPV6 = 16'hDD86;
    localparam logic [15:0] ET_ARP  = 16'h0608;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_INGRESS_LEN     = 16'd60;
    localparam logic [15:0] MIN_EGRESS_IPV4_LEN = 16'd34;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_EGRESS  = 2'd0,
        OP_INGRESS = 2'd1,
        OP_ADD     = 2'd2,
        OP_REMOVE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_FILTERED  = 3'd0,
        ST_ADDED     = 3'd1,
        ST_RAISED    = 3'd2,
        ST_LOWERED   = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CM_NEW  = 2'd0,
        CM_INC  = 2'd1,
        CM_DEC  = 2'd2,
        CM_FREE = 2'd3
    } t_commit_kind;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic        is_udp;
        logic [31:0] endpoint;
    } t_req;

    typedef struct packed {
        logic       permit;
        logic [2:0] table_status;
    } t_result;

    // Lookup token that walks the cell chain.
    typedef struct packed {
        logic             valid;
        logic             tbl;
        logic [31:0]      key;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [15:0]      hit_cnt;
        logic             free_any;
        logic [IDX_W-1:0] free_idx;
    } t_probe;

    // Table update broadcast to all cells at the end of a pass.
    typedef struct packed {
        logic             valid;
        t_commit_kind     kind;
        logic             tbl;
        logic [IDX_W-1:0] idx;
        logic [31:0]      key;
    } t_commit;

endpackage

// ===== design/ipaf_cell.sv =====
// One allowlist cell: holds one TCP and one UDP entry and forwards the lookup token.
// Depends on ipaf_pkg.
module ipaf_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ipaf_pkg::t_probe i_probe,
    output ipaf_pkg::t_probe o_probe,
    input  ipaf_pkg::t_commit i_commit
);
    localparam logic [ipaf_pkg::IDX_W-1:0] MY_IDX = ipaf_pkg::IDX_W'(IDX);

    logic [1:0]  r_used;
    logic [31:0] r_addr [2];
    logic [15:0] r_cnt  [2];
    ipaf_pkg::t_probe r_probe;
    ipaf_pkg::t_probe n_probe;

    always_comb begin
        n_probe = i_probe;
        if (!i_probe.hit && r_used[i_probe.tbl] && r_addr[i_probe.tbl] == i_probe.key) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = MY_IDX;
            n_probe.hit_cnt = r_cnt[i_probe.tbl];
        end
        // lowest free entry wins
        if (!i_probe.free_any && !r_used[i_probe.tbl]) begin
            n_probe.free_any = 1'b1;
            n_probe.free_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_commit.valid && i_commit.idx == MY_IDX) begin
            case (i_commit.kind)
                ipaf_pkg::CM_NEW:  r_used[i_commit.tbl] <= 1'b1;
                ipaf_pkg::CM_FREE: r_used[i_commit.tbl] <= 1'b0;
                default:           r_used <= r_used;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.valid && i_commit.idx == MY_IDX) begin
            case (i_commit.kind)
                ipaf_pkg::CM_NEW: begin
                    r_addr[i_commit.tbl] <= i_commit.key;
                    r_cnt[i_commit.tbl]  <= 16'd1;
                end
                ipaf_pkg::CM_INC: r_cnt[i_commit.tbl] <= r_cnt[i_commit.tbl] + 16'd1;
                ipaf_pkg::CM_DEC: r_cnt[i_commit.tbl] <= r_cnt[i_commit.tbl] - 16'd1;
                default:          r_cnt[i_commit.tbl] <= r_cnt[i_commit.tbl];
            endcase
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== design/ipaf_ctrl.sv =====
// Request capture, frame decision and table update command for the allowlist filter.
// Depends on ipaf_pkg.
module ipaf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ipaf_pkg::t_req    i_req,
    input  logic [31:0]       i_dns_addr,
    input  logic              i_dns_perm,
    output ipaf_pkg::t_probe  o_head,
    input  ipaf_pkg::t_probe  i_tail,
    output ipaf_pkg::t_commit o_commit,
    output logic              o_done,
    output ipaf_pkg::t_result o_result
);
    logic              r_busy;
    ipaf_pkg::t_req    r_req;
    ipaf_pkg::t_probe  r_head;
    ipaf_pkg::t_probe  n_head;
    logic              r_done;
    ipaf_pkg::t_result r_result;
    ipaf_pkg::t_result n_result;
    ipaf_pkg::t_commit n_commit;
    logic              w_accept;
    logic              w_egress;
    logic              w_arp_v6;
    logic              w_v4;
    logic              w_v4_ok;
    logic [31:0]       w_peer;

    assign w_accept = i_start && !r_busy;

    // Build the lookup token from the incoming request.
    always_comb begin
        n_head = '0;
        n_head.valid = 1'b1;
        unique case (ipaf_pkg::t_op'(i_req.operation))
            ipaf_pkg::OP_EGRESS: begin
                n_head.tbl = (i_req.ip_protocol == ipaf_pkg::PROTO_UDP);
                n_head.key = i_req.destination_address;
            end
            ipaf_pkg::OP_INGRESS: begin
                n_head.tbl = (i_req.ip_protocol == ipaf_pkg::PROTO_UDP);
                n_head.key = i_req.source_address;
            end
            ipaf_pkg::OP_ADD, ipaf_pkg::OP_REMOVE: begin
                n_head.tbl = i_req.is_udp;
                n_head.key = i_req.endpoint;
            end
        endcase
    end

    always_comb begin
        w_egress = (ipaf_pkg::t_op'(r_req.operation) == ipaf_pkg::OP_EGRESS);
        w_arp_v6 = (r_req.ether_type == ipaf_pkg::ET_ARP) ||
                   (r_req.ether_type == ipaf_pkg::ET_IPV6);
        w_v4     = (r_req.ether_type == ipaf_pkg::ET_IPV4);
        w_peer   = w_egress ? r_req.destination_address : r_req.source_address;
        if (r_req.ip_protocol == ipaf_pkg::PROTO_ICMP) begin
            w_v4_ok = 1'b1;
        end else if (r_req.ip_protocol == ipaf_pkg::PROTO_TCP) begin
            w_v4_ok = i_tail.hit;
        end else if (r_req.ip_protocol == ipaf_pkg::PROTO_UDP) begin
            w_v4_ok = (i_dns_addr == 32'd0) ||
                      (i_dns_perm && w_peer == i_dns_addr) ||
                      (w_egress && w_peer == ipaf_pkg::BCAST_ADDR) ||
                      i_tail.hit;
        end else begin
            w_v4_ok = 1'b0;
        end
    end

    // Decide once the token leaves the last cell.
    always_comb begin
        n_result = '0;
        n_commit = '0;
        n_commit.valid = 1'b0;
        n_commit.kind  = ipaf_pkg::CM_NEW;
        n_commit.tbl   = i_tail.tbl;
        n_commit.key   = i_tail.key;
        n_commit.idx   = i_tail.hit_idx;
        unique case (ipaf_pkg::t_op'(r_req.operation))
            ipaf_pkg::OP_EGRESS: begin
                n_result.table_status = ipaf_pkg::ST_FILTERED;
                n_result.permit = w_arp_v6 ||
                    (w_v4 && r_req.frame_length >= ipaf_pkg::MIN_EGRESS_IPV4_LEN && w_v4_ok);
            end
            ipaf_pkg::OP_INGRESS: begin
                n_result.table_status = ipaf_pkg::ST_FILTERED;
                n_result.permit = (r_req.frame_length >= ipaf_pkg::MIN_INGRESS_LEN) &&
                                  (w_arp_v6 || (w_v4 && w_v4_ok));
            end
            ipaf_pkg::OP_ADD: begin
                if (i_tail.hit) begin
                    if (i_tail.hit_cnt == ipaf_pkg::COUNT_MAX) begin
                        n_result.table_status = ipaf_pkg::ST_FULL;
                    end else begin
                        n_result.table_status = ipaf_pkg::ST_RAISED;
                        n_commit.valid = i_tail.valid;
                        n_commit.kind  = ipaf_pkg::CM_INC;
                    end
                end else if (i_tail.free_any) begin
                    n_result.table_status = ipaf_pkg::ST_ADDED;
                    n_commit.valid = i_tail.valid;
                    n_commit.kind  = ipaf_pkg::CM_NEW;
                    n_commit.idx   = i_tail.free_idx;
                end else begin
                    n_result.table_status = ipaf_pkg::ST_FULL;
                end
            end
            ipaf_pkg::OP_REMOVE: begin
                if (!i_tail.hit) begin
                    n_result.table_status = ipaf_pkg::ST_NOT_FOUND;
                end else if (i_tail.hit_cnt > 16'd1) begin
                    n_result.table_status = ipaf_pkg::ST_LOWERED;
                    n_commit.valid = i_tail.valid;
                    n_commit.kind  = ipaf_pkg::CM_DEC;
                end else begin
                    n_result.table_status = ipaf_pkg::ST_REMOVED;
                    n_commit.valid = i_tail.valid;
                    n_commit.kind  = ipaf_pkg::CM_FREE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_head <= '0;
        end else begin
            r_done <= i_tail.valid;
            r_head <= w_accept ? n_head : '0;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (i_tail.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (i_tail.valid) begin
            r_result <= n_result;
        end
    end

    assign o_busy   = r_busy;
    assign o_head   = r_head;
    assign o_commit = n_commit;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== design/ipv4_endpoint_allowlist_filter_core.sv =====
// Top level of the IPv4 endpoint allowlist filter: APB registers, control and cell chain.
// Depends on ipaf_pkg, ipaf_cell and ipaf_ctrl.
//
// Usage:
//   Requests enter on i_req when start is high and busy is low. A request either
//   classifies one frame (egress or ingress) or adds/removes an endpoint in the
//   TCP or UDP allowlist. Each request yields one result on o_result, marked by
//   a one-cycle o_done strobe; the receiver must take it in that cycle.
//   A lookup token walks a row of TABLE_ENTRIES cells, one cell per cycle, each
//   cell holding one TCP and one UDP entry. After the last cell the controller
//   decides, broadcasts any table update and registers the result.
//   The token is registered at the head, then in each cell in turn, and o_done
//   is registered from the token leaving the last cell. busy stays high until
//   the token leaves the last cell, so a new request can enter only once the
//   previous one has passed the whole chain; the chain length sets how soon.
//   Reset (synchronous, i_rst_n low) clears all used bits, the DNS registers and
//   the control state; no clearing pass is needed.
//   Registers: 0x0 DNS server address, 0x4 DNS permitted; write only while idle.
module ipv4_endpoint_allowlist_filter_core #(
    parameter int unsigned TABLE_ENTRIES = ipaf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ipaf_pkg::t_req    i_req,
    output logic              o_done,
    output ipaf_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic REG_DNS_ADDR = 1'b0;
    localparam logic REG_DNS_PERM = 1'b1;

    logic [31:0]       r_dns_addr;
    logic              r_dns_perm;
    logic              w_wr;
    ipaf_pkg::t_probe  w_probe [TABLE_ENTRIES+1];
    ipaf_pkg::t_commit w_commit;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dns_addr <= 32'd0;
            r_dns_perm <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_DNS_ADDR: r_dns_addr <= pwdata;
                REG_DNS_PERM: r_dns_perm <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DNS_ADDR: prdata = r_dns_addr;
            REG_DNS_PERM: prdata = {31'd0, r_dns_perm};
        endcase
    end

    ipaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req      (i_req),
        .i_dns_addr (r_dns_addr),
        .i_dns_perm (r_dns_perm),
        .o_head     (w_probe[0]),
        .i_tail     (w_probe[TABLE_ENTRIES]),
        .o_commit   (w_commit),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ipaf_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_probe  (w_probe[g]),
            .o_probe  (w_probe[g+1]),
            .i_commit (w_commit)
        );
    end

endmodule
